### design/mtpa_pkg.sv
// ---------------------------------------------------------------------------
// mtpa_pkg: shared types and constants of the masked temporal pixel average
// Widths of pixel, sum and count fields, gray weights, and the command and
// status structs that join the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package mtpa_pkg;

  localparam int ChanW  = 8;
  localparam int SumW   = 12;
  localparam int CntW   = 4;
  localparam int GrayW  = 8;
  localparam int ThrW   = 8;
  localparam int RemW   = 4;

  localparam int NeighboursDefault = 4;
  localparam logic [ThrW-1:0]  ThresholdReset = 8'd15;
  localparam logic [ChanW-1:0] ChannelMax     = 8'd255;
  localparam int CountLimit = 15;

  // Gray weights in Q14 with rounding offset.
  localparam int ProdW     = 22;
  localparam int GrayShift = 14;
  localparam int GrayCoefB = 1868;
  localparam int GrayCoefG = 9617;
  localparam int GrayCoefR = 4899;
  localparam int GrayRound = 8192;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic             is_reference;
    logic             set_end;
  } pix_t;

  typedef struct packed {
    logic [ChanW-1:0] avg_blue;
    logic [ChanW-1:0] avg_green;
    logic [ChanW-1:0] avg_red;
    logic [CntW-1:0]  used_count;
  } res_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic produce;
  } status_t;

endpackage

`default_nettype wire

### design/mtpa_stream_if.sv
// ---------------------------------------------------------------------------
// mtpa_stream_if: valid/ready channel with a typed payload
// One transfer happens at a rising edge where valid and ready are both high.
// ---------------------------------------------------------------------------
`default_nettype none

interface mtpa_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

### design/mtpa_datapath.sv
// ---------------------------------------------------------------------------
// mtpa_datapath: gray, match test, accumulators and three-lane divider
// Holds the threshold register, the open pixel set, a restoring divider per
// channel and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mtpa_datapath import mtpa_pkg::*; #(
  parameter int NEIGHBOURS_EACH_SIDE = NeighboursDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output status_t               status_o,
  input  wire pix_t             pixel_i,
  input  wire logic             cfg_we_i,
  input  wire logic [ThrW-1:0]  cfg_data_i,
  output res_t                  result_o
);

  localparam int CapRaw = 1 + 2 * NEIGHBOURS_EACH_SIDE;
  localparam int CapInt = (CapRaw > CountLimit) ? CountLimit : CapRaw;
  localparam logic [CntW-1:0] CountCap = CntW'(CapInt);
  localparam int Lanes = 3;

  function automatic logic [ChanW-1:0] round_half_even(
    input logic [SumW-1:0] quo,
    input logic [RemW-1:0] rem,
    input logic [CntW-1:0] div
  );
    logic [RemW:0] twice;
    logic          up;
    logic [SumW:0] rounded;
    twice   = {rem, 1'b0};
    up      = (twice > {1'b0, div}) || ((twice == {1'b0, div}) && quo[0]);
    rounded = {1'b0, quo} + (SumW + 1)'(up);
    return (rounded > (SumW + 1)'(ChannelMax)) ? ChannelMax : rounded[ChanW-1:0];
  endfunction

  logic [ThrW-1:0]  thr_q;
  pix_t             pix_q;
  logic [GrayW-1:0] gray_q, gray_d;
  logic [GrayW-1:0] ref_gray_q;
  logic [SumW-1:0]  sum_q [Lanes];
  logic [CntW-1:0]  count_q;
  logic [SumW-1:0]  num_q [Lanes];
  logic [RemW-1:0]  rem_q [Lanes];
  logic [CntW-1:0]  div_q;
  res_t             res_q;

  logic [ProdW-1:0] gray_sum;
  logic [GrayW-1:0] diff;
  logic             match;
  logic [ChanW-1:0] pix_chan [Lanes];

  assign pix_chan[0] = pix_q.blue;
  assign pix_chan[1] = pix_q.green;
  assign pix_chan[2] = pix_q.red;

  always_comb begin
    gray_sum = ProdW'(GrayCoefB) * ProdW'(pixel_i.blue)
             + ProdW'(GrayCoefG) * ProdW'(pixel_i.green)
             + ProdW'(GrayCoefR) * ProdW'(pixel_i.red)
             + ProdW'(GrayRound);
    gray_d   = gray_sum[GrayShift +: GrayW];
  end

  assign diff  = (gray_q > ref_gray_q) ? (gray_q - ref_gray_q) : (ref_gray_q - gray_q);
  assign match = diff < thr_q;

  // A set yields a result when it ends while open, or when a reference ends it.
  assign status_o.produce = pix_q.set_end && (pix_q.is_reference || (count_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThresholdReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q  <= pixel_i;
      gray_q <= gray_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_gray_q <= '0;
      count_q    <= '0;
      for (int l = 0; l < Lanes; l++) begin
        sum_q[l] <= '0;
      end
    end else if (cmd_i.update) begin
      if (pix_q.is_reference) begin
        ref_gray_q <= gray_q;
        count_q    <= CntW'(1);
        for (int l = 0; l < Lanes; l++) begin
          sum_q[l] <= SumW'(pix_chan[l]);
        end
      end else if ((count_q != '0) && (count_q < CountCap) && match) begin
        count_q <= count_q + CntW'(1);
        for (int l = 0; l < Lanes; l++) begin
          sum_q[l] <= sum_q[l] + SumW'(pix_chan[l]);
        end
      end
    end else if (cmd_i.div_start) begin
      // The set is handed to the divider and closed.
      ref_gray_q <= '0;
      count_q    <= '0;
      for (int l = 0; l < Lanes; l++) begin
        sum_q[l] <= '0;
      end
    end
  end

  // Restoring division, one quotient bit per lane per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_q <= count_q;
      for (int l = 0; l < Lanes; l++) begin
        num_q[l] <= sum_q[l];
        rem_q[l] <= '0;
      end
    end else if (cmd_i.div_step) begin
      for (int l = 0; l < Lanes; l++) begin
        if ({rem_q[l], num_q[l][SumW-1]} >= {1'b0, div_q}) begin
          rem_q[l] <= RemW'({rem_q[l], num_q[l][SumW-1]} - {1'b0, div_q});
          num_q[l] <= {num_q[l][SumW-2:0], 1'b1};
        end else begin
          rem_q[l] <= {rem_q[l][RemW-2:0], num_q[l][SumW-1]};
          num_q[l] <= {num_q[l][SumW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q.avg_blue   <= round_half_even(num_q[0], rem_q[0], div_q);
      res_q.avg_green  <= round_half_even(num_q[1], rem_q[1], div_q);
      res_q.avg_red    <= round_half_even(num_q[2], rem_q[2], div_q);
      res_q.used_count <= div_q;
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

### design/mtpa_ctrl.sv
// ---------------------------------------------------------------------------
// mtpa_ctrl: sequencer of the masked temporal pixel average
// Steps each item through capture and update, runs the divider for a set
// that ends, and owns the valid flag of the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mtpa_ctrl import mtpa_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    pix_valid_i,
  output logic         pix_ready_o,
  output logic         res_valid_o,
  input  wire logic    res_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StUpdate  = 3'd1;
  localparam logic [2:0] StStart   = 3'd2;
  localparam logic [2:0] StDivide  = 3'd3;
  localparam logic [2:0] StDeliver = 3'd4;

  localparam logic [CntW-1:0] StepLast = CntW'(SumW - 1);

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] step_q, step_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    pix_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        pix_ready_o = 1'b1;
        if (pix_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.produce ? StStart : StIdle;
      end
      StStart: begin
        cmd_o.div_start = 1'b1;
        step_d          = '0;
        state_d         = StDivide;
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + CntW'(1);
        if (step_q == StepLast) begin
          state_d = StDeliver;
        end
      end
      StDeliver: begin
        // The result register takes the new result once it is empty or drained.
        if (!out_valid_q || res_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;

endmodule

`default_nettype wire

### design/masked_temporal_pixel_average.sv
// ---------------------------------------------------------------------------
// masked_temporal_pixel_average: per-pixel temporal denoise blend
// Averages a target pixel with those warped neighbour pixels whose gray
// value lies within a programmable threshold of the target's gray value.
// ---------------------------------------------------------------------------
// Usage:
//   pix_i carries one BGR pixel per transfer. A transfer with is_reference
//   opens a pixel set; following neighbour pixels join it when their gray
//   differs from the target's by less than match_threshold. The transfer
//   with set_end closes the set and yields one transfer on res_o with the
//   per-channel averages (rounded half to even) and the pixel count.
//   cfg_i writes match_threshold; it is always ready and should be used
//   only while no set is being processed.
// Timing:
//   Every pixel passes through capture with gray, then match and
//   accumulate, before the next is taken. A pixel that closes a set then
//   also passes through divider start, the 12-step bit-serial divider that
//   works on the three channels side by side, and loading of the result.
// Reset and stalls:
//   Reset closes any open set, sets match_threshold to 15 and empties the
//   result register. A result waiting on res_o does not block pix_i; only
//   the next result waits until the held one is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module masked_temporal_pixel_average import mtpa_pkg::*; #(
  parameter int NEIGHBOURS_EACH_SIDE = NeighboursDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  mtpa_stream_if.sink   pix_i,
  mtpa_stream_if.source res_o,
  mtpa_stream_if.sink   cfg_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_i.ready = 1'b1;

  mtpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mtpa_datapath #(
    .NEIGHBOURS_EACH_SIDE (NEIGHBOURS_EACH_SIDE)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .pixel_i    (pix_i.payload),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.payload),
    .result_o   (res_o.payload)
  );

endmodule

`default_nettype wire

### design/mtpa_checker.sv
// ---------------------------------------------------------------------------
// mtpa_checker: port-level checks of the masked temporal pixel average
// Watches the pixel and result channels and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module mtpa_checker import mtpa_pkg::*; #(
  parameter int NEIGHBOURS_EACH_SIDE = NeighboursDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic pix_valid_i,
  input wire logic pix_ready_i,
  input wire logic res_valid_i,
  input wire logic res_ready_i,
  input wire res_t res_payload_i
);

  localparam int CapRaw = 1 + 2 * NEIGHBOURS_EACH_SIDE;
  localparam int CapInt = (CapRaw > CountLimit) ? CountLimit : CapRaw;
  localparam logic [CntW-1:0] CountCap = CntW'(CapInt);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_payload_i))
    else $error("result payload changed while stalled");

  // The count covers the target and is never above the count cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_payload_i.used_count != '0) &&
                    (res_payload_i.used_count <= CountCap))
    else $error("used_count out of range");

  // Each pixel is worked on before the next is taken, so pixels are never taken back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i |=> !pix_ready_i)
    else $error("pixel taken on consecutive cycles");

endmodule

bind masked_temporal_pixel_average mtpa_checker #(
  .NEIGHBOURS_EACH_SIDE (NEIGHBOURS_EACH_SIDE)
) u_mtpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pix_valid_i   (pix_i.valid),
  .pix_ready_i   (pix_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_payload_i (res_o.payload)
);

`default_nettype wire

### tb/sv/mtpa_blend_checker.sv
// ---------------------------------------------------------------------------
// mtpa_blend_checker: prediction and result checking for the pixel average
// Watches the pixel, result and threshold channels, keeps its own copy of
// the open pixel set and the threshold, queues the averages that each
// closing pixel should produce and compares every result transfer with the
// oldest queued average.
// ---------------------------------------------------------------------------
module mtpa_blend_checker import mtpa_pkg::*; #(
  parameter int NEIGHBOURS_EACH_SIDE = NeighboursDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pix_valid_i,
  input  logic            pix_ready_i,
  input  pix_t            pix_i,
  input  logic            res_valid_i,
  input  logic            res_ready_i,
  input  res_t            res_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [ThrW-1:0] cfg_data_i,
  output int              pending_o,
  output int              errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CountCapRaw = 1 + 2 * NEIGHBOURS_EACH_SIDE;
  localparam int CountCap    = (CountCapRaw > CountLimit) ? CountLimit : CountCapRaw;

  logic [ThrW-1:0]  threshold;
  logic [GrayW-1:0] target_gray;
  logic [SumW-1:0]  sum_blue;
  logic [SumW-1:0]  sum_green;
  logic [SumW-1:0]  sum_red;
  logic [CntW-1:0]  pixel_count;
  res_t             expected_avgs[$];
  int               mismatches = 0;
  int               waiting = 0;

  assign pending_o = waiting;
  assign errors_o  = mismatches;

  function automatic logic [ChanW-1:0] round_half_even(logic [SumW-1:0] sum,
                                                       logic [CntW-1:0] cnt);
    int q;
    int r;
    q = int'(sum) / int'(cnt);
    r = int'(sum) % int'(cnt);
    if (2 * r > int'(cnt) || (2 * r == int'(cnt) && q[0])) q++;
    if (q > int'(ChannelMax)) q = int'(ChannelMax);
    return q[ChanW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : sample_edge
    int   gray;
    int   diff;
    res_t avg;
    res_t seen;
    if (!rst_ni) begin
      threshold   = ThresholdReset;
      target_gray = '0;
      sum_blue    = '0;
      sum_green   = '0;
      sum_red     = '0;
      pixel_count = '0;
      expected_avgs.delete();
    end else begin
      // Results are checked first: a result transfer never belongs to a
      // pixel taken at the same edge.
      if (res_valid_i && res_ready_i) begin
        seen = res_i;
        if (expected_avgs.size() == 0) begin
          $error("res_o: transfer with no result expected (used_count %0d)",
                 seen.used_count);
          mismatches++;
        end else begin
          avg = expected_avgs.pop_front();
          if (seen.avg_blue !== avg.avg_blue) begin
            $error("avg_blue: expected %0d, actual %0d", avg.avg_blue, seen.avg_blue);
            mismatches++;
          end
          if (seen.avg_green !== avg.avg_green) begin
            $error("avg_green: expected %0d, actual %0d", avg.avg_green, seen.avg_green);
            mismatches++;
          end
          if (seen.avg_red !== avg.avg_red) begin
            $error("avg_red: expected %0d, actual %0d", avg.avg_red, seen.avg_red);
            mismatches++;
          end
          if (seen.used_count !== avg.used_count) begin
            $error("used_count: expected %0d, actual %0d", avg.used_count,
                   seen.used_count);
            mismatches++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) threshold = cfg_data_i;

      if (pix_valid_i && pix_ready_i) begin
        gray = (GrayCoefB * int'(pix_i.blue) + GrayCoefG * int'(pix_i.green) +
                GrayCoefR * int'(pix_i.red) + GrayRound) >> GrayShift;
        if (pix_i.is_reference) begin
          // A target pixel always restarts the set, dropping any open one.
          target_gray = gray[GrayW-1:0];
          sum_blue    = SumW'(pix_i.blue);
          sum_green   = SumW'(pix_i.green);
          sum_red     = SumW'(pix_i.red);
          pixel_count = CntW'(1);
        end else if (pixel_count != 0 && int'(pixel_count) < CountCap) begin
          diff = (gray > int'(target_gray)) ? gray - int'(target_gray)
                                            : int'(target_gray) - gray;
          if (diff < int'(threshold)) begin
            sum_blue    = sum_blue + SumW'(pix_i.blue);
            sum_green   = sum_green + SumW'(pix_i.green);
            sum_red     = sum_red + SumW'(pix_i.red);
            pixel_count = pixel_count + CntW'(1);
          end
        end
        if (pix_i.set_end && pixel_count != 0) begin
          avg.avg_blue   = round_half_even(sum_blue, pixel_count);
          avg.avg_green  = round_half_even(sum_green, pixel_count);
          avg.avg_red    = round_half_even(sum_red, pixel_count);
          avg.used_count = pixel_count;
          expected_avgs.insert(expected_avgs.size(), avg);
          target_gray = '0;
          sum_blue    = '0;
          sum_green   = '0;
          sum_red     = '0;
          pixel_count = '0;
        end
      end
    end
    waiting = expected_avgs.size();
  end

endmodule

### tb/sv/masked_temporal_pixel_average_tb.sv
// ---------------------------------------------------------------------------
// masked_temporal_pixel_average_tb: top of the pixel average testbench
// Drives pixel sets in bursts with random gaps, stalls the result channel
// on a pattern of its own, reprograms the match threshold between phases
// and reports the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module masked_temporal_pixel_average_tb import mtpa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Neighbours  = NeighboursDefault;
  localparam int DrainCycles = 24;
  localparam int PhaseItems  = 85;
  localparam int CycleLimit  = 200000;

  typedef logic [ThrW-1:0] thr_t;

  logic clk_i;
  logic rst_ni;
  int   pending;
  int   mismatches;
  int   burst_left = 0;
  int   sent = 0;

  mtpa_stream_if #(.payload_t(pix_t)) pix_if ();
  mtpa_stream_if #(.payload_t(res_t)) res_if ();
  mtpa_stream_if #(.payload_t(thr_t)) cfg_if ();

  masked_temporal_pixel_average #(
    .NEIGHBOURS_EACH_SIDE(Neighbours)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  mtpa_blend_checker #(
    .NEIGHBOURS_EACH_SIDE(Neighbours)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_valid_i(pix_if.valid),
    .pix_ready_i(pix_if.ready),
    .pix_i      (pix_if.payload),
    .res_valid_i(res_if.valid),
    .res_ready_i(res_if.ready),
    .res_i      (res_if.payload),
    .cfg_valid_i(cfg_if.valid),
    .cfg_ready_i(cfg_if.ready),
    .cfg_data_i (cfg_if.payload),
    .pending_o  (pending),
    .errors_o   (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result receiver: modes of varying stall density, including none at all.
  always @(posedge clk_i) begin : result_stalls
    int mode_left;
    int stall_left;
    int stall_odds;
    if (!rst_ni) begin
      mode_left  = 0;
      stall_left = 0;
      stall_odds = 0;
      res_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left  = $urandom_range(16, 96);
        stall_odds = $urandom_range(0, 3);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, 7) < stall_odds) begin
        stall_left = $urandom_range(0, 7);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(logic [ChanW-1:0] b, logic [ChanW-1:0] g,
                            logic [ChanW-1:0] r, bit is_ref, bit last);
    pix_t p;
    p.blue         = b;
    p.green        = g;
    p.red          = r;
    p.is_reference = is_ref;
    p.set_end      = last;
    if (burst_left == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
    end
    pix_if.valid   <= 1'b1;
    pix_if.payload <= p;
    do @(posedge clk_i); while (!pix_if.ready);
    burst_left--;
    sent++;
  endtask

  // Stops the pixel stream and waits until every queued average has been
  // seen, then lets a set that closed without a result finish as well.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_threshold(thr_t value);
    wait_drained();
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [ChanW-1:0] near_value(logic [ChanW-1:0] c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > int'(ChannelMax)) v = int'(ChannelMax);
    return v[ChanW-1:0];
  endfunction

  // Mostly well-formed sets around a random target; some sets lose their
  // end marker and some items carry random flags.
  task automatic send_random_set();
    int               kind;
    int               n;
    int               spread;
    logic [ChanW-1:0] tb_blue;
    logic [ChanW-1:0] tb_green;
    logic [ChanW-1:0] tb_red;
    kind     = $urandom_range(0, 9);
    tb_blue  = ChanW'($urandom_range(0, 255));
    tb_green = ChanW'($urandom_range(0, 255));
    tb_red   = ChanW'($urandom_range(0, 255));
    if (kind == 0) begin
      repeat ($urandom_range(1, 4))
        send_pixel(ChanW'($urandom_range(0, 255)), ChanW'($urandom_range(0, 255)),
                   ChanW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    end else begin
      n = $urandom_range(0, 10);
      case ($urandom_range(0, 3))
        0: spread = 2;
        1: spread = 8;
        2: spread = 30;
        default: spread = 255;
      endcase
      send_pixel(tb_blue, tb_green, tb_red, 1'b1, n == 0);
      for (int i = 0; i < n; i++)
        send_pixel(near_value(tb_blue, spread), near_value(tb_green, spread),
                   near_value(tb_red, spread), 1'b0, (i == n - 1) && (kind != 1));
    end
  endtask

  initial begin
    thr_t level;
    rst_ni = 1'b0;
    pix_if.valid   <= 1'b0;
    pix_if.payload <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= ThresholdReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Neighbours with no open set are dropped, with or without an end mark.
    send_pixel(8'd128, 8'd64, 8'd32, 1'b0, 1'b1);
    send_pixel(8'd7, 8'd7, 8'd7, 1'b0, 1'b0);
    // A target that closes its own set, at both channel extremes.
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
    // A second target drops the open set; 5/2 rounds down to even.
    send_pixel(8'd10, 8'd20, 8'd30, 1'b1, 1'b0);
    send_pixel(8'd2, 8'd2, 8'd2, 1'b1, 1'b0);
    send_pixel(8'd3, 8'd3, 8'd3, 1'b0, 1'b1);
    // 3/2 rounds up to even.
    send_pixel(8'd1, 8'd1, 8'd1, 1'b1, 1'b0);
    send_pixel(8'd2, 8'd2, 8'd2, 1'b0, 1'b1);
    // A neighbour far from the target is rejected.
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
    // More matching neighbours than the count cap allows.
    send_pixel(8'd100, 8'd100, 8'd100, 1'b1, 1'b0);
    for (int i = 0; i < 2 * Neighbours + 1; i++)
      send_pixel(8'd100, 8'd100, 8'd100, 1'b0, i == 2 * Neighbours);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: level = thr_t'(0);
        1: level = ChannelMax;
        2: level = thr_t'(1);
        3: level = thr_t'($urandom_range(0, 255));
        4: level = thr_t'(40);
        5: level = thr_t'(4);
        6: level = thr_t'($urandom_range(2, 60));
        default: level = ThresholdReset;
      endcase
      program_threshold(level);
      sent = 0;
      while (sent < PhaseItems) send_random_set();
    end

    wait_drained();
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
